@@ hw/rtl/srit_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srit_pkg: shared types and codes of the sorted record table
// Record layout, status codes, operation kinds; used by all but srit_ram.
// ----------------------------------------------------------------------------
package srit_pkg;

    localparam int TABLE_DEPTH_DEF = 128;

    localparam logic       KIND_INSERT = 1'b0;
    localparam logic       KIND_READ   = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [21:0] key;
        logic [15:0] tag;
        logic        expiry;
        logic [7:0]  quantity;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic   move_up;
        t_entry wdata;
    } t_step;

endpackage

@@ hw/rtl/srit_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srit_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module srit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/srit_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srit_step: compare and select unit
// Compares the new key with one stored record and picks the record to write.
// ----------------------------------------------------------------------------
module srit_step (
    input  srit_pkg::t_entry i_new,
    input  srit_pkg::t_entry i_stored,
    output srit_pkg::t_step  o_step
);

    always_comb begin
        o_step.move_up = (i_new.key < i_stored.key);
        o_step.wdata   = o_step.move_up ? i_stored : i_new;
    end

endmodule

@@ hw/rtl/sorted_record_insert_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_record_insert_table: table of records kept in ascending key order
// An insert walks the table from the top slot down, moving each record with
// a greater key up one slot, then places the new record; a read fetches the
// record at an index.
//
// Usage: drive the item fields and raise start; the item transfers at an
// edge where start is high and busy is low. The result appears on the o_*
// ports for one cycle with o_valid high and must be taken then.
// Walk: an insert into a non-empty table enters S_SCAN, which reads one
// stored record per slot and writes it one slot up (or writes the new
// record above it and ends); if every record moves, S_PLACE writes the new
// record to slot 0. The result is registered and shown in the next cycle.
// A read passes through S_READ for the registered RAM read. An insert into
// an empty table, a dropped insert into a full table or a read beyond the
// count returns straight from S_IDLE, with no walk.
// busy is high for the whole walk; a new item may transfer in the cycle its
// predecessor's result is shown.
// Reset empties the table at once; the RAM holds no reset value.
// ----------------------------------------------------------------------------
module sorted_record_insert_table #(
    parameter int TABLE_DEPTH = srit_pkg::TABLE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_kind,
    input  logic [21:0] i_sort_key,
    input  logic [13:0] i_date_year,
    input  logic [3:0]  i_date_month,
    input  logic [4:0]  i_date_day,
    input  logic [7:0]  i_item_quantity,
    input  logic        i_expiry_type,
    input  logic [15:0] i_label_tag,
    input  logic [6:0]  i_read_index,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [6:0]  o_slot_position,
    output logic [7:0]  o_entry_total,
    output logic [21:0] o_out_key,
    output logic [13:0] o_out_year,
    output logic [3:0]  o_out_month,
    output logic [4:0]  o_out_day,
    output logic [7:0]  o_out_quantity,
    output logic        o_out_expiry_type,
    output logic [15:0] o_out_label_tag
);

    localparam int AW   = $clog2(TABLE_DEPTH);
    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam int XW   = (CW > 8) ? CW : 8;
    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_PLACE,
        S_READ
    } t_state;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [AW-1:0]     r_idx, n_idx;
    srit_pkg::t_entry  r_rec, n_rec;
    logic [XW-1:0]     r_slot, n_slot;
    logic              r_valid, n_valid;
    logic [1:0]        r_status, n_status;
    logic [XW-1:0]     r_total, n_total;
    srit_pkg::t_entry  r_out, n_out;

    srit_pkg::t_entry  w_in_rec;
    srit_pkg::t_entry  w_rdata;
    srit_pkg::t_step   w_step;
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    srit_pkg::t_entry  w_wdata;
    logic [AW-1:0]     w_raddr;
    logic [XW-1:0]     w_count_x;
    logic [XW-1:0]     w_ridx_x;
    logic [XW-1:0]     w_up_slot;

    always_comb begin
        w_in_rec.key      = i_sort_key;
        w_in_rec.tag      = i_label_tag;
        w_in_rec.expiry   = i_expiry_type;
        w_in_rec.quantity = i_item_quantity;
        w_in_rec.day      = i_date_day;
        w_in_rec.month    = i_date_month;
        w_in_rec.year     = i_date_year;
    end

    assign w_count_x = XW'(r_count);
    assign w_ridx_x  = XW'(i_read_index);
    assign w_up_slot = XW'(r_idx) + XW'(1);

    srit_ram #(
        .WIDTH (srit_pkg::ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    srit_step u_step (
        .i_new    (r_rec),
        .i_stored (w_rdata),
        .o_step   (w_step)
    );

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_rec    = r_rec;
        n_slot   = r_slot;
        n_valid  = 1'b0;
        n_status = r_status;
        n_total  = r_total;
        n_out    = r_out;
        w_we     = 1'b0;
        w_waddr  = AW'(w_up_slot);
        w_wdata  = w_step.wdata;
        w_raddr  = r_idx - AW'(1);

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_rec   = w_in_rec;
                    n_total = w_count_x;
                    n_out   = '0;
                    if (i_kind == srit_pkg::KIND_INSERT) begin
                        if (r_count == FULL_COUNT) begin
                            n_valid  = 1'b1;
                            n_status = srit_pkg::ST_FULL;
                            n_slot   = '0;
                        end else if (r_count == '0) begin
                            w_we     = 1'b1;
                            w_waddr  = '0;
                            w_wdata  = w_in_rec;
                            n_count  = CW'(1);
                            n_valid  = 1'b1;
                            n_status = srit_pkg::ST_OK;
                            n_slot   = '0;
                            n_total  = XW'(1);
                        end else begin
                            n_idx   = AW'(r_count - CW'(1));
                            w_raddr = AW'(r_count - CW'(1));
                            n_state = S_SCAN;
                        end
                    end else begin
                        n_slot = w_ridx_x;
                        if (w_ridx_x >= w_count_x) begin
                            n_valid  = 1'b1;
                            n_status = srit_pkg::ST_RANGE;
                        end else begin
                            w_raddr = w_ridx_x[AW-1:0];
                            n_state = S_READ;
                        end
                    end
                end
            end
            S_SCAN: begin
                w_we = 1'b1;
                if (w_step.move_up) begin
                    if (r_idx == '0) begin
                        n_state = S_PLACE;
                    end else begin
                        n_idx = r_idx - AW'(1);
                    end
                end else begin
                    n_count  = r_count + CW'(1);
                    n_valid  = 1'b1;
                    n_status = srit_pkg::ST_OK;
                    n_slot   = w_up_slot;
                    n_total  = w_count_x + XW'(1);
                    n_state  = S_IDLE;
                end
            end
            S_PLACE: begin
                w_we     = 1'b1;
                w_waddr  = '0;
                w_wdata  = r_rec;
                n_count  = r_count + CW'(1);
                n_valid  = 1'b1;
                n_status = srit_pkg::ST_OK;
                n_slot   = '0;
                n_total  = w_count_x + XW'(1);
                n_state  = S_IDLE;
            end
            S_READ: begin
                n_valid  = 1'b1;
                n_status = srit_pkg::ST_OK;
                n_out    = w_rdata;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
        r_idx    <= n_idx;
        r_rec    <= n_rec;
        r_slot   <= n_slot;
        r_status <= n_status;
        r_total  <= n_total;
        r_out    <= n_out;
    end

    assign busy              = (r_state != S_IDLE);
    assign o_valid           = r_valid;
    assign o_status          = r_status;
    assign o_slot_position   = r_slot[6:0];
    assign o_entry_total     = r_total[7:0];
    assign o_out_key         = r_out.key;
    assign o_out_year        = r_out.year;
    assign o_out_month       = r_out.month;
    assign o_out_day         = r_out.day;
    assign o_out_quantity    = r_out.quantity;
    assign o_out_expiry_type = r_out.expiry;
    assign o_out_label_tag   = r_out.tag;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("record count exceeds table depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |->
        (r_count == $past(r_count) || r_count == $past(r_count) + CW'(1)))
        else $error("record count moved by more than one");

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_valid))
        else $error("transfer neither started a walk nor gave a result");

    a_scan_ports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_idx != '0) |-> (w_waddr != w_raddr))
        else $error("walk reads and writes the same slot");

    a_walk_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && !w_step.move_up) |=> (o_valid && o_status == srit_pkg::ST_OK))
        else $error("finished insert gave no result");

endmodule

@@ tb/sv/sorted_record_insert_table_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_record_insert_table_test: self-checking bench for the sorted table
// Sends insert and read commands in random bursts and keeps a shadow copy of
// the table that yields the expected reply for every transfer. Each reply
// strobe is compared field by field. The run covers directed corner cases,
// a mixed phase that fills the table, and a phase on the full table.
// ----------------------------------------------------------------------------
module sorted_record_insert_table_test;

    localparam int          DEPTH      = srit_pkg::TABLE_DEPTH_DEF;
    localparam int          ITEM_GOAL  = 1450;
    localparam int          IDLE_LIMIT = 2000;
    localparam logic [21:0] KEY_MAX    = 22'h3FFFFF;

    typedef struct {
        logic        kind;
        logic [21:0] key;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [7:0]  quantity;
        logic        expiry;
        logic [15:0] tag;
        logic [6:0]  index;
    } t_record_cmd;

    typedef struct {
        logic [1:0]       status;
        logic [6:0]       slot;
        logic [7:0]       total;
        srit_pkg::t_entry rec;
    } t_table_reply;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_kind;
    logic [21:0] i_sort_key;
    logic [13:0] i_date_year;
    logic [3:0]  i_date_month;
    logic [4:0]  i_date_day;
    logic [7:0]  i_item_quantity;
    logic        i_expiry_type;
    logic [15:0] i_label_tag;
    logic [6:0]  i_read_index;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [6:0]  o_slot_position;
    logic [7:0]  o_entry_total;
    logic [21:0] o_out_key;
    logic [13:0] o_out_year;
    logic [3:0]  o_out_month;
    logic [4:0]  o_out_day;
    logic [7:0]  o_out_quantity;
    logic        o_out_expiry_type;
    logic [15:0] o_out_label_tag;

    srit_pkg::t_entry shadow_table [DEPTH];
    int               shadow_count   = 0;
    t_table_reply     replies_due [$];
    int               fail_count     = 0;
    int               burst_left     = 0;
    int               transfers_sent = 0;
    int               idle_cycles    = 0;
    int               n_placed       = 0;
    int               n_dropped      = 0;
    int               n_read_ok      = 0;
    int               n_read_range   = 0;

    sorted_record_insert_table #(.TABLE_DEPTH(DEPTH)) DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_kind            (i_kind),
        .i_sort_key        (i_sort_key),
        .i_date_year       (i_date_year),
        .i_date_month      (i_date_month),
        .i_date_day        (i_date_day),
        .i_item_quantity   (i_item_quantity),
        .i_expiry_type     (i_expiry_type),
        .i_label_tag       (i_label_tag),
        .i_read_index      (i_read_index),
        .o_valid           (o_valid),
        .o_status          (o_status),
        .o_slot_position   (o_slot_position),
        .o_entry_total     (o_entry_total),
        .o_out_key         (o_out_key),
        .o_out_year        (o_out_year),
        .o_out_month       (o_out_month),
        .o_out_day         (o_out_day),
        .o_out_quantity    (o_out_quantity),
        .o_out_expiry_type (o_out_expiry_type),
        .o_out_label_tag   (o_out_label_tag)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_table_reply apply_to_shadow_table(input t_record_cmd cmd);
        t_table_reply     r;
        srit_pkg::t_entry e;
        int               pos;
        int               k;
        bit               found;
        r.status = srit_pkg::ST_OK;
        r.slot   = '0;
        r.total  = '0;
        r.rec    = '0;
        if (cmd.kind == srit_pkg::KIND_INSERT) begin
            if (shadow_count >= DEPTH) begin
                r.status = srit_pkg::ST_FULL;
                r.total  = 8'(shadow_count);
            end else begin
                pos   = shadow_count;
                found = 1'b0;
                for (k = 0; k < shadow_count; k++) begin
                    if (!found && cmd.key < shadow_table[k].key) begin
                        pos   = k;
                        found = 1'b1;
                    end
                end
                for (k = shadow_count; k > pos; k--) begin
                    shadow_table[k] = shadow_table[k - 1];
                end
                e.key      = cmd.key;
                e.tag      = cmd.tag;
                e.expiry   = cmd.expiry;
                e.quantity = cmd.quantity;
                e.day      = cmd.day;
                e.month    = cmd.month;
                e.year     = cmd.year;
                shadow_table[pos] = e;
                shadow_count++;
                r.slot  = 7'(pos);
                r.total = 8'(shadow_count);
            end
        end else begin
            r.slot  = cmd.index;
            r.total = 8'(shadow_count);
            if (int'(cmd.index) >= shadow_count) begin
                r.status = srit_pkg::ST_RANGE;
            end else begin
                r.rec = shadow_table[cmd.index];
            end
        end
        return r;
    endfunction

    function automatic t_record_cmd make_record(input logic kind, input logic [21:0] key,
                                                input logic [13:0] year, input logic [3:0] month,
                                                input logic [4:0] day, input logic [7:0] quantity,
                                                input logic expiry, input logic [15:0] tag,
                                                input logic [6:0] index);
        t_record_cmd c;
        c.kind     = kind;
        c.key      = key;
        c.year     = year;
        c.month    = month;
        c.day      = day;
        c.quantity = quantity;
        c.expiry   = expiry;
        c.tag      = tag;
        c.index    = index;
        return c;
    endfunction

    function automatic t_record_cmd random_record(input logic kind);
        t_record_cmd c;
        c.kind = kind;
        case ($urandom_range(5))
            0, 1:    c.key = 22'($urandom_range(32'h3FFFFF));
            2:       c.key = 22'($urandom_range(15));
            3:       c.key = 22'($urandom_range(32'h3FFFFF, 32'h3FFFF0));
            4:       c.key = $urandom_range(1) ? KEY_MAX : 22'd0;
            default: c.key = (shadow_count > 0) ?
                             shadow_table[$urandom_range(shadow_count - 1)].key : 22'd0;
        endcase
        c.year     = 14'($urandom_range(9999, 1));
        c.month    = 4'($urandom_range(12, 1));
        c.day      = 5'($urandom_range(31, 1));
        c.quantity = 8'($urandom_range(255));
        c.expiry   = 1'($urandom_range(1));
        c.tag      = 16'($urandom_range(65535));
        if (shadow_count > 0 && (shadow_count >= DEPTH || $urandom_range(4) != 0)) begin
            c.index = 7'($urandom_range(shadow_count - 1));
        end else begin
            c.index = 7'($urandom_range(DEPTH - 1, shadow_count));
        end
        return c;
    endfunction

    task automatic issue_record(input t_record_cmd cmd);
        int           gap;
        t_table_reply r;
        if (burst_left == 0) begin
            gap = ($urandom_range(3) == 0) ? $urandom_range(150, 13) : $urandom_range(12, 1);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(3) == 0) ? $urandom_range(60, 20) : $urandom_range(8, 1);
        end
        i_kind          <= cmd.kind;
        i_sort_key      <= cmd.key;
        i_date_year     <= cmd.year;
        i_date_month    <= cmd.month;
        i_date_day      <= cmd.day;
        i_item_quantity <= cmd.quantity;
        i_expiry_type   <= cmd.expiry;
        i_label_tag     <= cmd.tag;
        i_read_index    <= cmd.index;
        start           <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        r = apply_to_shadow_table(cmd);
        replies_due.push_back(r);
        if (cmd.kind == srit_pkg::KIND_INSERT) begin
            if (r.status == srit_pkg::ST_FULL) n_dropped++;
            else n_placed++;
        end else begin
            if (r.status == srit_pkg::ST_RANGE) n_read_range++;
            else n_read_ok++;
        end
        burst_left--;
        transfers_sent++;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : check_replies
        t_table_reply want;
        if (i_rst_n && o_valid) begin
            if (replies_due.size() == 0) begin
                $error("reply strobe with no transfer pending");
                fail_count++;
            end else begin
                want = replies_due.pop_front();
                check_field("status", want.status, o_status);
                check_field("slot_position", want.slot, o_slot_position);
                check_field("entry_total", want.total, o_entry_total);
                check_field("out_key", want.rec.key, o_out_key);
                check_field("out_year", want.rec.year, o_out_year);
                check_field("out_month", want.rec.month, o_out_month);
                check_field("out_day", want.rec.day, o_out_day);
                check_field("out_quantity", want.rec.quantity, o_out_quantity);
                check_field("out_expiry_type", want.rec.expiry, o_out_expiry_type);
                check_field("out_label_tag", want.rec.tag, o_out_label_tag);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("sorted_record_insert_table_test failed");
            $finish;
        end
    end

    task automatic test_directed_cases();
        int i;
        issue_record(make_record(srit_pkg::KIND_READ, 22'd0, 14'd1, 4'd1, 5'd1,
                                 8'd0, 1'b0, 16'd0, 7'd0));
        issue_record(make_record(srit_pkg::KIND_READ, KEY_MAX, 14'd1, 4'd1, 5'd1,
                                 8'd0, 1'b0, 16'd0, 7'd127));
        issue_record(make_record(srit_pkg::KIND_INSERT, 22'd100, 14'd1, 4'd1, 5'd1,
                                 8'd0, 1'b0, 16'd0, 7'd0));
        issue_record(make_record(srit_pkg::KIND_INSERT, KEY_MAX, 14'd9999, 4'd12, 5'd31,
                                 8'd255, 1'b1, 16'hFFFF, 7'd127));
        issue_record(make_record(srit_pkg::KIND_INSERT, 22'd0, 14'd2024, 4'd6, 5'd15,
                                 8'd7, 1'b1, 16'h1234, 7'd0));
        issue_record(make_record(srit_pkg::KIND_INSERT, 22'd100, 14'd5000, 4'd2, 5'd28,
                                 8'd128, 1'b0, 16'h8000, 7'd64));
        issue_record(make_record(srit_pkg::KIND_INSERT, 22'd100, 14'd8191, 4'd8, 5'd16,
                                 8'd1, 1'b1, 16'h00FF, 7'd1));
        issue_record(make_record(srit_pkg::KIND_INSERT, KEY_MAX, 14'd8192, 4'd7, 5'd30,
                                 8'd254, 1'b0, 16'hFF00, 7'd126));
        issue_record(make_record(srit_pkg::KIND_INSERT, 22'd101, 14'd1234, 4'd3, 5'd3,
                                 8'd33, 1'b1, 16'h5A5A, 7'd2));
        for (i = 0; i < 7; i++) begin
            issue_record(make_record(srit_pkg::KIND_READ, 22'($urandom_range(32'h3FFFFF)),
                                     14'd1, 4'd1, 5'd1, 8'd0, 1'b0, 16'd0, 7'(i)));
        end
        issue_record(make_record(srit_pkg::KIND_READ, 22'd0, 14'd1, 4'd1, 5'd1,
                                 8'd0, 1'b0, 16'd0, 7'd7));
        issue_record(make_record(srit_pkg::KIND_READ, 22'd0, 14'd1, 4'd1, 5'd1,
                                 8'd0, 1'b0, 16'd0, 7'd127));
        issue_record(make_record(srit_pkg::KIND_INSERT, 22'd0, 14'd42, 4'd11, 5'd9,
                                 8'd99, 1'b0, 16'hA5A5, 7'd5));
        issue_record(make_record(srit_pkg::KIND_READ, 22'd0, 14'd1, 4'd1, 5'd1,
                                 8'd0, 1'b0, 16'd0, 7'd1));
    endtask

    task automatic test_fill_with_reads();
        while (shadow_count < DEPTH) begin
            issue_record(random_record(($urandom_range(3) == 0) ?
                                       srit_pkg::KIND_INSERT : srit_pkg::KIND_READ));
        end
    endtask

    task automatic test_full_table();
        while (transfers_sent < ITEM_GOAL) begin
            issue_record(random_record($urandom_range(1) ?
                                       srit_pkg::KIND_INSERT : srit_pkg::KIND_READ));
        end
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        start           <= 1'b0;
        i_kind          <= srit_pkg::KIND_INSERT;
        i_sort_key      <= '0;
        i_date_year     <= '0;
        i_date_month    <= '0;
        i_date_day      <= '0;
        i_item_quantity <= '0;
        i_expiry_type   <= 1'b0;
        i_label_tag     <= '0;
        i_read_index    <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_fill_with_reads();
        test_full_table();
        start <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (DEPTH + 8) @(posedge i_clk);
        $display("Ran %0d transfers: %0d inserts placed, %0d inserts dropped on a full table.",
                 transfers_sent, n_placed, n_dropped);
        $display("Reads: %0d within the count, %0d past the count; table holds %0d records.",
                 n_read_ok, n_read_range, shadow_count);
        if (fail_count == 0) begin
            $display("sorted_record_insert_table_test passed");
        end else begin
            $display("sorted_record_insert_table_test failed");
        end
        $finish;
    end

endmodule
